// ===== hdl/lcm_pkg.sv =====
// Shared types and constants for the link credit manager.
// Holds the operation codes and the item layouts of the two channels.
// No dependencies.
package lcm_pkg;

  // Operation codes carried in the op field of an input item.
  typedef enum logic [2:0] {
    OP_CONSUME   = 3'd0,
    OP_LOCAL_RET = 3'd1,
    OP_LINK_RET  = 3'd2,
    OP_QUERY     = 3'd3,
    OP_BUILD     = 3'd4,
    OP_LOAD      = 3'd5
  } op_t;

  // Width of the wrapping per-channel statistics counters.
  localparam int CNT_W = 32;

  // Largest amount a single built link return can carry.
  localparam logic [CNT_W-1:0] RETURN_MAX = 32'd4;

  // One input item.
  typedef struct packed {
    logic [2:0] op;
    logic [1:0] port;
    logic [1:0] chan;
    logic [9:0] count;
    logic [1:0] link_code;
    logic       pool_return;
    logic       ready_flag;
    logic       shared_pool;
    logic       entry_enable;
    logic [9:0] load_credits;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic             granted;
    logic [9:0]       available;
    logic             return_valid;
    logic [1:0]       return_chan;
    logic [1:0]       return_code;
    logic             port_ready;
    logic [CNT_W-1:0] consumed_total;
    logic [CNT_W-1:0] returned_total;
    logic [CNT_W-1:0] blocked_total;
  } res_t;

endpackage

// ===== hdl/lcm_cmd_if.sv =====
// Valid/ready channel that carries input items into the credit manager.
// Depends on lcm_pkg for the item layout.
interface lcm_cmd_if
  import lcm_pkg::*;
();
  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/lcm_res_if.sv =====
// Valid/ready channel that carries result items out of the credit manager.
// Depends on lcm_pkg for the item layout.
interface lcm_res_if
  import lcm_pkg::*;
();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/link_credit_manager_top.sv =====
// Top level of the link credit manager: port and channel entry memories,
// the read-modify-write pipeline and the result register.
// Depends on lcm_pkg, lcm_cmd_if, lcm_res_if and lcm_update.
//
//   channel | direction | payload | accepted when
//   --------+-----------+---------+----------------------------
//   cmd     | in        | cmd_t   | cmd.valid && cmd.ready
//   res     | out       | res_t   | res.valid && res.ready
//
// One item per cycle sustained while res is not stalled. An accepted item
// reads both memories at the accept edge; it is written back as the result
// register loads. Back-to-back items on the same entry are forwarded.
// Reset clears the entry valid bits at once, so no clearing pass is needed.
// A stalled res holds the item in the update stage and drops cmd.ready.
module link_credit_manager_top
  import lcm_pkg::*;
#(
  parameter int NUM_PORTS = 4,
  parameter int NUM_CHANNELS = 4,
  parameter int CREDIT_BITS = 10
) (
  input logic      clk,
  input logic      rst,
  lcm_cmd_if.sink  cmd,
  lcm_res_if.source res
);

  localparam int NE = NUM_PORTS * NUM_CHANNELS;
  localparam int EIDX_W = (NE > 1) ? $clog2(NE) : 1;
  localparam int PIDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int PW = 2 * CREDIT_BITS + 2;
  localparam int EW = 2 * CREDIT_BITS + 1 + 3 * CNT_W;

  // Entry memories and their valid bits.
  logic [PW-1:0] port_mem [NUM_PORTS];
  logic [EW-1:0] ent_mem [NE];
  logic [NUM_PORTS-1:0] port_vld;
  logic [NE-1:0]        ent_vld;

  // Per-entry summary of the consumed counter, used by build return.
  logic [NE-1:0] used_nz;
  logic [1:0]    used_code [NE];

  // Update stage.
  logic              s1_vld;
  cmd_t              s1_item;
  logic              s1_inr;
  logic [EIDX_W-1:0] s1_eaddr;
  logic [PIDX_W-1:0] s1_paddr;
  logic [PW-1:0]     port_rd;
  logic [EW-1:0]     ent_rd;
  logic              port_rd_vld;
  logic              ent_rd_vld;
  logic              port_fwd;
  logic              ent_fwd;
  logic [PW-1:0]     port_fwd_data;
  logic [EW-1:0]     ent_fwd_data;

  // Result register.
  logic res_vld;
  res_t res_data;

  logic              accept;
  logic              advance;
  logic              wr_en;
  logic              in_inr;
  logic [EIDX_W-1:0] in_eaddr;
  logic [PIDX_W-1:0] in_paddr;
  logic [PW-1:0]     port_cur;
  logic [EW-1:0]     ent_cur;
  logic [PW-1:0]     port_next;
  logic [EW-1:0]     ent_next;
  logic [CNT_W-1:0]  used_next;
  res_t              result;
  logic [NUM_CHANNELS-1:0]      nz_vec;
  logic [NUM_CHANNELS-1:0][1:0] code_vec;

  // Handshake: the update stage moves on whenever the result register is free.
  assign advance = !res_vld || res.ready;
  assign cmd.ready = !s1_vld || advance;
  assign accept = cmd.valid && cmd.ready;
  assign wr_en = s1_vld && advance && s1_inr;
  assign res.valid = res_vld;
  assign res.data = res_data;

  // Entry addresses of the incoming item; out-of-range items use entry zero.
  always_comb begin
    in_inr = (32'(cmd.data.port) < NUM_PORTS) && (32'(cmd.data.chan) < NUM_CHANNELS);
    in_eaddr = '0;
    in_paddr = '0;
    if (in_inr) begin
      in_eaddr = EIDX_W'(32'(cmd.data.port) * NUM_CHANNELS + 32'(cmd.data.chan));
      in_paddr = PIDX_W'(cmd.data.port);
    end
  end

  // Memory reads at accept and write-back from the update stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      port_rd <= port_mem[in_paddr];
      ent_rd <= ent_mem[in_eaddr];
    end
    if (wr_en) begin
      port_mem[s1_paddr] <= port_next;
      ent_mem[s1_eaddr] <= ent_next;
    end
  end

  // Stage payload and forwarding data.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= cmd.data;
      s1_inr <= in_inr;
      s1_eaddr <= in_eaddr;
      s1_paddr <= in_paddr;
      port_fwd_data <= port_next;
      ent_fwd_data <= ent_next;
    end
    if (advance && s1_vld) begin
      res_data <= result;
    end
  end

  // Control state: valid bits, forwarding flags and stage occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      res_vld <= 1'b0;
      port_vld <= '0;
      ent_vld <= '0;
      used_nz <= '0;
      port_rd_vld <= 1'b0;
      ent_rd_vld <= 1'b0;
      port_fwd <= 1'b0;
      ent_fwd <= 1'b0;
    end else begin
      if (accept) begin
        s1_vld <= 1'b1;
        port_rd_vld <= port_vld[in_paddr];
        ent_rd_vld <= ent_vld[in_eaddr];
        // A write-back in this same cycle to the entry being read is forwarded.
        port_fwd <= wr_en && (s1_paddr == in_paddr);
        ent_fwd <= wr_en && (s1_eaddr == in_eaddr);
      end else if (advance) begin
        s1_vld <= 1'b0;
      end
      if (advance && s1_vld) begin
        res_vld <= 1'b1;
      end else if (res.ready) begin
        res_vld <= 1'b0;
      end
      if (wr_en) begin
        port_vld[s1_paddr] <= 1'b1;
        ent_vld[s1_eaddr] <= 1'b1;
        used_nz[s1_eaddr] <= (used_next != '0);
      end
    end
  end

  // Saturated code of the consumed counter kept beside the nonzero flag.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      used_code[s1_eaddr] <= (used_next > RETURN_MAX) ? 2'd3 : 2'(used_next - 1'b1);
    end
  end

  // Current entries: forwarded data, memory data, or zero if never written.
  always_comb begin
    if (port_fwd) begin
      port_cur = port_fwd_data;
    end else if (port_rd_vld) begin
      port_cur = port_rd;
    end else begin
      port_cur = '0;
    end
    if (ent_fwd) begin
      ent_cur = ent_fwd_data;
    end else if (ent_rd_vld) begin
      ent_cur = ent_rd;
    end else begin
      ent_cur = '0;
    end
  end

  // Consumed summaries of every channel of the addressed port.
  always_comb begin
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      nz_vec[k] = 1'b0;
      code_vec[k] = '0;
      if (s1_inr) begin
        nz_vec[k] = used_nz[EIDX_W'(32'(s1_paddr) * NUM_CHANNELS + k)];
        code_vec[k] = used_code[EIDX_W'(32'(s1_paddr) * NUM_CHANNELS + k)];
      end
    end
  end

  // The consumed counter sits in the low fields of the channel entry.
  assign used_next = ent_next[3*CNT_W-1:2*CNT_W];

  lcm_update #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .CREDIT_BITS(CREDIT_BITS)
  ) u_update (
    .item(s1_item),
    .in_range(s1_inr),
    .port_cur(port_cur),
    .ent_cur(ent_cur),
    .used_nz(nz_vec),
    .used_code(code_vec),
    .port_next(port_next),
    .ent_next(ent_next),
    .result(result)
  );

endmodule

// ===== hdl/lcm_update.sv =====
// Read-modify-write datapath of the credit manager: applies one operation to
// the port entry and channel entry read from memory and forms the result item.
// Depends on lcm_pkg.
module lcm_update
  import lcm_pkg::*;
#(
  parameter int NUM_CHANNELS = 4,
  parameter int CREDIT_BITS = 10,
  localparam int PW = 2 * CREDIT_BITS + 2,
  localparam int EW = 2 * CREDIT_BITS + 1 + 3 * CNT_W
) (
  input  cmd_t                          item,
  input  logic                          in_range,
  input  logic [PW-1:0]                 port_cur,
  input  logic [EW-1:0]                 ent_cur,
  input  logic [NUM_CHANNELS-1:0]       used_nz,
  input  logic [NUM_CHANNELS-1:0][1:0]  used_code,
  output logic [PW-1:0]                 port_next,
  output logic [EW-1:0]                 ent_next,
  output res_t                          result
);

  localparam int AMT_W = (CREDIT_BITS > 10) ? CREDIT_BITS + 1 : 11;

  typedef struct packed {
    logic                   mode;
    logic                   rdy;
    logic [CREDIT_BITS-1:0] limit;
    logic [CREDIT_BITS-1:0] left;
  } port_ent_t;

  typedef struct packed {
    logic                   rdy;
    logic [CREDIT_BITS-1:0] limit;
    logic [CREDIT_BITS-1:0] left;
    logic [CNT_W-1:0]       used;
    logic [CNT_W-1:0]       given;
    logic [CNT_W-1:0]       stalled;
  } chan_ent_t;

  // Credits seen on (port, channel) for a given pair of entries.
  function automatic logic [CREDIT_BITS-1:0] credits_of(port_ent_t pe, chan_ent_t ce);
    logic [CREDIT_BITS-1:0] c;
    c = '0;
    if (pe.rdy) begin
      if (pe.mode) begin
        c = pe.left;
      end else if (ce.rdy) begin
        c = ce.left;
      end
    end
    return c;
  endfunction

  // Adds a return to a credit count, never going above its limit.
  function automatic logic [CREDIT_BITS-1:0] capped_add(logic [CREDIT_BITS-1:0] left,
                                                        logic [9:0] amount,
                                                        logic [CREDIT_BITS-1:0] limit);
    logic [AMT_W-1:0] sum;
    sum = AMT_W'(left) + AMT_W'(amount);
    return (sum > AMT_W'(limit)) ? limit : CREDIT_BITS'(sum);
  endfunction

  port_ent_t              pc;
  port_ent_t              pn;
  chan_ent_t              cc;
  chan_ent_t              cn;
  logic [9:0]             amount;
  logic                   to_pool;
  logic [CREDIT_BITS-1:0] avail_now;
  logic [CREDIT_BITS-1:0] avail_after;
  logic                   granted;
  logic                   rvalid;
  logic [1:0]             rchan;
  logic [1:0]             rcode;

  assign pc = port_ent_t'(port_cur);
  assign cc = chan_ent_t'(ent_cur);
  assign avail_now = credits_of(pc, cc);

  // Returns go to the pool or to the channel depending on the operation.
  always_comb begin
    if (op_t'(item.op) == OP_LOCAL_RET) begin
      amount = item.count;
      to_pool = pc.mode;
    end else begin
      amount = 10'(item.link_code) + 10'd1;
      to_pool = item.pool_return;
    end
  end

  // Apply the operation to the two entries.
  always_comb begin
    pn = pc;
    cn = cc;
    granted = 1'b0;
    rvalid = 1'b0;
    rchan = '0;
    rcode = '0;
    case (op_t'(item.op))
      OP_CONSUME: begin
        if (avail_now != '0) begin
          granted = 1'b1;
          if (pc.mode) begin
            pn.left = pc.left - 1'b1;
          end else begin
            cn.left = cc.left - 1'b1;
            cn.used = cc.used + 1'b1;
          end
        end else if (!pc.mode) begin
          cn.stalled = cc.stalled + 1'b1;
        end
      end
      OP_LOCAL_RET, OP_LINK_RET: begin
        if (to_pool) begin
          pn.left = capped_add(pc.left, amount, pc.limit);
        end else begin
          cn.left = capped_add(cc.left, amount, cc.limit);
          cn.given = cc.given + CNT_W'(amount);
        end
        if (op_t'(item.op) == OP_LINK_RET && item.ready_flag) begin
          pn.rdy = 1'b1;
        end
      end
      OP_BUILD: begin
        // Lowest channel with consumed credits wins.
        if (pc.rdy && !pc.mode) begin
          for (int k = NUM_CHANNELS - 1; k >= 0; k--) begin
            if (used_nz[k]) begin
              rvalid = 1'b1;
              rchan = 2'(k);
              rcode = used_code[k];
            end
          end
        end
      end
      OP_LOAD: begin
        pn.mode = item.shared_pool;
        if (item.shared_pool) begin
          pn.limit = CREDIT_BITS'(item.load_credits);
          pn.left = CREDIT_BITS'(item.load_credits);
        end else if (item.entry_enable) begin
          cn.limit = CREDIT_BITS'(item.load_credits);
          cn.left = CREDIT_BITS'(item.load_credits);
          cn.rdy = 1'b1;
        end
        pn.rdy = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign avail_after = credits_of(pn, cn);
  assign port_next = PW'(pn);
  assign ent_next = EW'(cn);

  // Result item; an out-of-range address answers with all zeros.
  always_comb begin
    result = '0;
    if (in_range) begin
      result.granted = granted;
      result.available = 10'(avail_after);
      result.return_valid = rvalid;
      result.return_chan = rchan;
      result.return_code = rcode;
      result.port_ready = pn.rdy;
      result.consumed_total = cn.used;
      result.returned_total = cn.given;
      result.blocked_total = cn.stalled;
    end
  end

endmodule

// ===== hdl/lcm_checker.sv =====
// Port-level checks of the link credit manager's result items.
// Depends on lcm_pkg; bound to link_credit_manager_top below.
module lcm_checker
  import lcm_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_ready,
  input res_t res_data
);

  // A built return and a granted consume never come from the same item.
  a_grant_xor_return: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_data.granted && res_data.return_valid))
    else $error("granted and return_valid both set");

  // Without a built return its channel and code fields stay zero.
  a_return_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_data.return_valid) |->
      (res_data.return_chan == 2'd0 && res_data.return_code == 2'd0))
    else $error("return fields set without return_valid");

  // Credits are only reported for a port that is ready.
  a_avail_ready: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.available != 10'd0) |-> res_data.port_ready)
    else $error("credits reported on a port that is not ready");

  // A stalled result item holds until taken.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
    else $error("result item changed while stalled");

endmodule

bind link_credit_manager_top lcm_checker u_lcm_checker (
  .clk(clk),
  .rst(rst),
  .res_valid(res.valid),
  .res_ready(res.ready),
  .res_data(res.data)
);
